/* rtl/uer_pkg.sv */
package uer_pkg;

  // Field widths
  localparam int unsigned CountW  = 13;
  localparam int unsigned WaitW   = 12;
  localparam int unsigned RiseW   = 10;
  localparam int unsigned DistW   = 10;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned CfgIdxW = 2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_RISE_TIMEOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FALL_TIMEOUT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PULSE_LIMIT  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DISTANCE = 2'd3;

  // Register reset values
  localparam logic [RiseW-1:0]  RISE_TIMEOUT_RST = 10'd100;
  localparam logic [WaitW-1:0]  FALL_TIMEOUT_RST = 12'd500;
  localparam logic [CountW-1:0] PULSE_LIMIT_RST  = 13'd5000;
  localparam logic [DistW-1:0]  MAX_DISTANCE_RST = 10'd400;

  // Sequencer phase codes
  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_RISE = 2'd1;
  localparam logic [1:0] PHASE_FALL = 2'd2;

  localparam logic [WaitW-1:0] WAIT_MAX = 12'd4095;

  // count*17 fits 18 bits; ceil(2^21/10) gives an exact /10 below 2^18
  localparam int unsigned ScaledW   = 18;
  localparam int unsigned RecipShft = 21;
  localparam logic [ScaledW-1:0] RECIP_TEN = 18'd209716;
  localparam int unsigned ProdW     = 2 * ScaledW;
  localparam int unsigned QuotW     = ProdW - RecipShft;

  // Output tdata layout, lowest bit up
  localparam int unsigned OUT_TRIG_BIT  = 0;
  localparam int unsigned OUT_BUSY_BIT  = 1;
  localparam int unsigned OUT_DONE_BIT  = 2;
  localparam int unsigned OUT_DIST_LSB  = 3;
  localparam int unsigned OUT_STAT_BIT  = OUT_DIST_LSB + DistW;
  localparam int unsigned OutDataW      = 16;
  localparam int unsigned InDataW       = 8;

  typedef struct packed {
    logic [RiseW-1:0]  rise_timeout;
    logic [WaitW-1:0]  fall_timeout;
    logic [CountW-1:0] pulse_limit;
    logic [DistW-1:0]  max_distance;
  } cfg_t;

  // Per-tick outcome of the sequencer, before distance scaling
  typedef struct packed {
    logic              trig;
    logic              busy;
    logic              done;
    logic [CountW-1:0] count;
  } tick_res_t;

endpackage

/* rtl/uer_seq.sv */
module uer_seq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    acc_i,
  input  logic                    echo_level_i,
  input  logic                    start_request_i,
  input  uer_pkg::cfg_t           cfg_i,
  output uer_pkg::tick_res_t      res_o
);

  logic [1:0]                  phase_q, phase_d;
  logic                        prev_q;
  logic                        meas_q, meas_d;
  logic [uer_pkg::CountW-1:0]  count_q, count_d;
  logic [uer_pkg::WaitW-1:0]   wait_q, wait_d;

  logic                        rise_edge, fall_edge;
  logic [uer_pkg::CountW-1:0]  cnt_e;
  logic                        meas_e;
  logic [uer_pkg::CountW:0]    cnt_inc;
  logic [uer_pkg::CountW-1:0]  cnt_u;
  logic                        meas_u;
  logic                        check, trig, done;
  logic [1:0]                  ph_a, ph_b;
  logic [uer_pkg::WaitW-1:0]   wait_a, wait_b;

  // Edge detect and pulse counting
  always_comb begin
    rise_edge = echo_level_i & ~prev_q;
    fall_edge = ~echo_level_i & prev_q;
    cnt_e     = rise_edge ? '0 : count_q;
    meas_e    = rise_edge ? 1'b1 : (fall_edge ? 1'b0 : meas_q);
    cnt_inc   = {1'b0, cnt_e} + {{uer_pkg::CountW{1'b0}}, 1'b1};
    cnt_u     = cnt_e;
    meas_u    = meas_e;
    if (meas_e && echo_level_i) begin
      if (cnt_inc > {1'b0, cfg_i.pulse_limit}) begin
        cnt_u  = '0;
        meas_u = 1'b0;
      end else begin
        cnt_u = cnt_inc[uer_pkg::CountW-1:0];
      end
    end
  end

  // Phase sequencer
  always_comb begin
    check   = 1'b0;
    trig    = 1'b0;
    done    = 1'b0;
    ph_a    = phase_q;
    wait_a  = wait_q;
    count_d = cnt_u;
    meas_d  = meas_u;
    if (phase_q == uer_pkg::PHASE_RISE || phase_q == uer_pkg::PHASE_FALL) begin
      if (wait_q < uer_pkg::WAIT_MAX) begin
        wait_a = wait_q + 1'b1;
      end
      check = 1'b1;
    end else begin
      ph_a = uer_pkg::PHASE_IDLE;
      if (start_request_i) begin
        trig    = 1'b1;
        count_d = '0;
        meas_d  = 1'b0;
        wait_a  = '0;
        ph_a    = uer_pkg::PHASE_RISE;
        check   = 1'b1;
      end
    end

    ph_b   = ph_a;
    wait_b = wait_a;
    if (check && ph_a == uer_pkg::PHASE_RISE) begin
      if (!(!meas_d && wait_a < {2'b00, cfg_i.rise_timeout})) begin
        ph_b   = uer_pkg::PHASE_FALL;
        wait_b = '0;
      end
    end

    phase_d = ph_b;
    wait_d  = wait_b;
    if (check && ph_b == uer_pkg::PHASE_FALL) begin
      if (!(meas_d && wait_b < cfg_i.fall_timeout)) begin
        done    = 1'b1;
        phase_d = uer_pkg::PHASE_IDLE;
        wait_d  = '0;
      end
    end
  end

  always_comb begin
    res_o.trig  = trig;
    res_o.busy  = (phase_d != uer_pkg::PHASE_IDLE);
    res_o.done  = done;
    res_o.count = count_d;
  end

  // State advances once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uer_pkg::PHASE_IDLE;
      prev_q  <= 1'b0;
      meas_q  <= 1'b0;
      count_q <= '0;
      wait_q  <= '0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      prev_q  <= echo_level_i;
      meas_q  <= meas_d;
      count_q <= count_d;
      wait_q  <= wait_d;
    end
  end

endmodule

/* rtl/ultrasonic_echo_ranger_top.sv */
// Each accepted item goes through the stage 1 register, then the output register.
// Throughput: one item per cycle while the output is not stalled; the sequencer
// state updates in the accept cycle, the count*17/10 scaling (one constant
// multiplier) runs in the second stage. Backpressure stalls both stages together;
// input is taken whenever the output register is empty or being drained.
// Reset (rst_ni low, asynchronous): idle phase, counters cleared, registers at defaults.
module ultrasonic_echo_ranger_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [uer_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [uer_pkg::CfgW-1:0]        cfg_wdata_i,
  // input items
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [uer_pkg::InDataW-1:0]     s_axis_tdata,  // [0] echo_level, [1] start_request
  // result items
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [uer_pkg::OutDataW-1:0]    m_axis_tdata   // [0] trigger_pulse, [1] busy_res,
                                                         // [2] done_res, [12:3] distance_cm,
                                                         // [13] status
);

  uer_pkg::cfg_t       cfg_q;
  uer_pkg::tick_res_t  tick_res;
  uer_pkg::tick_res_t  st_res_q;
  logic                st_valid_q;
  logic                out_valid_q;
  logic [uer_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic                adv, in_acc;

  logic [uer_pkg::ScaledW-1:0] scaled;
  logic [uer_pkg::ProdW-1:0]   prod;
  logic [uer_pkg::QuotW-1:0]   quot;
  logic [uer_pkg::DistW-1:0]   dist_cm;
  logic                        no_echo;

  assign adv           = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && adv;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rise_timeout <= uer_pkg::RISE_TIMEOUT_RST;
      cfg_q.fall_timeout <= uer_pkg::FALL_TIMEOUT_RST;
      cfg_q.pulse_limit  <= uer_pkg::PULSE_LIMIT_RST;
      cfg_q.max_distance <= uer_pkg::MAX_DISTANCE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        uer_pkg::CFG_RISE_TIMEOUT: cfg_q.rise_timeout <= cfg_wdata_i[uer_pkg::RiseW-1:0];
        uer_pkg::CFG_FALL_TIMEOUT: cfg_q.fall_timeout <= cfg_wdata_i[uer_pkg::WaitW-1:0];
        uer_pkg::CFG_PULSE_LIMIT:  cfg_q.pulse_limit  <= cfg_wdata_i[uer_pkg::CountW-1:0];
        uer_pkg::CFG_MAX_DISTANCE: cfg_q.max_distance <= cfg_wdata_i[uer_pkg::DistW-1:0];
        default: ;
      endcase
    end
  end

  uer_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .acc_i           (in_acc),
    .echo_level_i    (s_axis_tdata[0]),
    .start_request_i (s_axis_tdata[1]),
    .cfg_i           (cfg_q),
    .res_o           (tick_res)
  );

  // Stage 1 register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (adv) begin
      st_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      st_res_q <= tick_res;
    end
  end

  // Distance: count*17 by shift-add, /10 by reciprocal multiply, then saturate
  always_comb begin
    scaled  = {1'b0, st_res_q.count, 4'b0000}
            + {{(uer_pkg::ScaledW-uer_pkg::CountW){1'b0}}, st_res_q.count};
    prod    = scaled * uer_pkg::RECIP_TEN;
    quot    = prod[uer_pkg::ProdW-1:uer_pkg::RecipShft];
    no_echo = (st_res_q.count == '0);
    if (no_echo || quot > {{(uer_pkg::QuotW-uer_pkg::DistW){1'b0}}, cfg_q.max_distance}) begin
      dist_cm = cfg_q.max_distance;
    end else begin
      dist_cm = quot[uer_pkg::DistW-1:0];
    end

    out_data_d = '0;
    out_data_d[uer_pkg::OUT_TRIG_BIT] = st_res_q.trig;
    out_data_d[uer_pkg::OUT_BUSY_BIT] = st_res_q.busy;
    out_data_d[uer_pkg::OUT_DONE_BIT] = st_res_q.done;
    if (st_res_q.done) begin
      out_data_d[uer_pkg::OUT_STAT_BIT-1:uer_pkg::OUT_DIST_LSB] = dist_cm;
      out_data_d[uer_pkg::OUT_STAT_BIT] = no_echo;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= st_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && st_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

/* rtl/uer_checker.sv */
module uer_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tready,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [uer_pkg::OutDataW-1:0]  m_axis_tdata
);

  logic trig, busy, done, stat;
  logic [uer_pkg::DistW-1:0] dist_cm;

  assign trig    = m_axis_tdata[uer_pkg::OUT_TRIG_BIT];
  assign busy    = m_axis_tdata[uer_pkg::OUT_BUSY_BIT];
  assign done    = m_axis_tdata[uer_pkg::OUT_DONE_BIT];
  assign stat    = m_axis_tdata[uer_pkg::OUT_STAT_BIT];
  assign dist_cm = m_axis_tdata[uer_pkg::OUT_STAT_BIT-1:uer_pkg::OUT_DIST_LSB];

  // a stalled result item stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  // an empty output register never blocks the input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a finished measurement leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && done |-> !busy)
    else $error("done reported while busy");

  // distance and status only accompany a report
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !done |-> dist_cm == '0 && !stat)
    else $error("distance or status without done");

  // a trigger without an immediate report starts a wait
  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && trig && !done |-> busy)
    else $error("trigger without busy");

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned RandomTicks = 950;
  localparam int unsigned PhaseTicks  = 110;
  localparam int unsigned HoldCycles  = 64;
  localparam int unsigned DrainCycles = 4;     // a little over the two-stage latency
  localparam int unsigned LongRun     = 250;   // long echo, count well into the hundreds
  localparam int unsigned ScaleNum    = 17;
  localparam int unsigned ScaleDen    = 10;
  localparam int unsigned DirRows     = 33;

  // One result item, field by field
  typedef struct packed {
    logic                      trig;
    logic                      busy;
    logic                      done;
    logic [uer_pkg::DistW-1:0] dist_cm;
    logic                      stat;
  } echo_report_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  // Directed row: a tick (report typed in or left to the model) or a register write
  typedef struct packed {
    row_kind_e                   kind;
    logic                        typed;
    logic                        echo;
    logic                        start;
    logic [uer_pkg::CfgIdxW-1:0] idx;
    logic [uer_pkg::CfgW-1:0]    val;
    echo_report_t                want;
  } dir_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [uer_pkg::CfgIdxW-1:0]   cfg_idx_i;
  logic [uer_pkg::CfgW-1:0]      cfg_wdata_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [uer_pkg::InDataW-1:0]   s_axis_tdata;   // [0] echo_level, [1] start_request
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [uer_pkg::OutDataW-1:0]  m_axis_tdata;   // [0] trigger_pulse, [1] busy_res,
                                                 // [2] done_res, [12:3] distance_cm,
                                                 // [13] status

  // Ranging model state and register copy
  uer_pkg::cfg_t                 ranger_cfg;
  logic [1:0]                    seq_phase;
  logic                          echo_prev;
  logic                          measuring;
  logic [uer_pkg::CountW-1:0]    pulse_cnt;
  logic [uer_pkg::WaitW-1:0]     wait_cnt;

  echo_report_t         pending_reports [$];
  logic                 row_typed;
  echo_report_t         row_want;
  logic                 no_idle;
  dir_row_t             dir_tab [DirRows];

  int unsigned          errors;
  int unsigned          ticks_sent;
  int unsigned          reports_seen;
  int unsigned          no_echo_seen;
  int unsigned          reg_writes;
  int unsigned          items_drained;
  int unsigned          cycle_count;

  ultrasonic_echo_ranger_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // One tick of the ranger: edge tracking first, then the sequencer
  function automatic echo_report_t range_tick(input logic echo, input logic start);
    echo_report_t             r;
    logic [uer_pkg::CountW:0] next_cnt;
    logic                     check;
    int unsigned              scaled;
    r     = '0;
    check = 1'b0;
    if (echo && !echo_prev) begin
      pulse_cnt = '0;
      measuring = 1'b1;
    end else if (!echo && echo_prev) begin
      measuring = 1'b0;
    end
    if (measuring && echo) begin
      next_cnt = {1'b0, pulse_cnt} + 1'b1;
      if (next_cnt > {1'b0, ranger_cfg.pulse_limit}) begin
        measuring = 1'b0;
        pulse_cnt = '0;
      end else begin
        pulse_cnt = next_cnt[uer_pkg::CountW-1:0];
      end
    end
    echo_prev = echo;

    if (seq_phase == uer_pkg::PHASE_RISE || seq_phase == uer_pkg::PHASE_FALL) begin
      if (wait_cnt != uer_pkg::WAIT_MAX) wait_cnt = wait_cnt + 1'b1;
      check = 1'b1;
    end else begin
      // unused code falls back to idle
      seq_phase = uer_pkg::PHASE_IDLE;
      if (start) begin
        r.trig    = 1'b1;
        pulse_cnt = '0;
        measuring = 1'b0;
        wait_cnt  = '0;
        seq_phase = uer_pkg::PHASE_RISE;
        check     = 1'b1;
      end
    end

    if (check && seq_phase == uer_pkg::PHASE_RISE &&
        (measuring || wait_cnt >= ranger_cfg.rise_timeout)) begin
      seq_phase = uer_pkg::PHASE_FALL;
      wait_cnt  = '0;
    end
    if (check && seq_phase == uer_pkg::PHASE_FALL &&
        (!measuring || wait_cnt >= ranger_cfg.fall_timeout)) begin
      r.done = 1'b1;
      if (pulse_cnt != '0) begin
        scaled    = (int'(pulse_cnt) * ScaleNum) / ScaleDen;
        r.dist_cm = (scaled > ranger_cfg.max_distance) ? ranger_cfg.max_distance
                                                       : scaled[uer_pkg::DistW-1:0];
      end else begin
        r.dist_cm = ranger_cfg.max_distance;
        r.stat    = 1'b1;
      end
      seq_phase = uer_pkg::PHASE_IDLE;
      wait_cnt  = '0;
    end
    r.busy = (seq_phase != uer_pkg::PHASE_IDLE);
    return r;
  endfunction

  function automatic dir_row_t tick_open(input logic echo, input logic start);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_TICK;
    r.echo  = echo;
    r.start = start;
    return r;
  endfunction

  function automatic dir_row_t tick_known(input logic echo, input logic start,
                                          input logic trig, input logic busy,
                                          input logic done, input int unsigned dist_cm,
                                          input logic stat);
    dir_row_t r;
    r              = tick_open(echo, start);
    r.typed        = 1'b1;
    r.want.trig    = trig;
    r.want.busy    = busy;
    r.want.done    = done;
    r.want.dist_cm = dist_cm[uer_pkg::DistW-1:0];
    r.want.stat    = stat;
    return r;
  endfunction

  function automatic dir_row_t reg_row(input logic [uer_pkg::CfgIdxW-1:0] idx,
                                       input int unsigned val);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.val  = val[uer_pkg::CfgW-1:0];
    return r;
  endfunction

  // Largest value of a register of the given width
  function automatic logic [uer_pkg::CfgW-1:0] full_scale(input int unsigned w);
    int unsigned v;
    v = (1 << w) - 1;
    return v[uer_pkg::CfgW-1:0];
  endfunction

  // Mostly the low end, now and then an extreme
  function automatic logic [uer_pkg::CfgW-1:0] pick_setting(input int unsigned top,
                                                            input int unsigned usual);
    int unsigned v;
    case ($urandom_range(0, 5))
      0:       v = 1;
      1:       v = top;
      default: v = $urandom_range(1, usual);
    endcase
    return v[uer_pkg::CfgW-1:0];
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    end
  endtask

  // Offer one tick after a random gap; returns at the falling edge after acceptance
  task automatic send_tick(input logic echo, input logic start, input logic typed,
                           input echo_report_t want);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(uer_pkg::InDataW-2){1'b0}}, start, echo};
    row_typed     <= typed;
    row_want      <= want;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Register write once the block has drained
  task automatic write_reg(input logic [uer_pkg::CfgIdxW-1:0] idx,
                           input logic [uer_pkg::CfgW-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      uer_pkg::CFG_RISE_TIMEOUT: ranger_cfg.rise_timeout = val[uer_pkg::RiseW-1:0];
      uer_pkg::CFG_FALL_TIMEOUT: ranger_cfg.fall_timeout = val[uer_pkg::WaitW-1:0];
      uer_pkg::CFG_PULSE_LIMIT:  ranger_cfg.pulse_limit  = val[uer_pkg::CountW-1:0];
      uer_pkg::CFG_MAX_DISTANCE: ranger_cfg.max_distance = val[uer_pkg::DistW-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic body_tick(input logic level, input int unsigned glitch_odds);
    logic flip;
    flip = (glitch_odds != 0) && ($urandom_range(1, glitch_odds) == 1);
    send_tick(level ^ flip, $urandom_range(0, 15) == 0, 1'b0, '0);
  endtask

  // Start, quiet lead-in, echo pulse, quiet tail; lead and width sized to timeouts
  task automatic echo_episode(input int unsigned glitch_odds);
    int unsigned lead, width, tail, rise_cap, fall_cap;
    rise_cap = ranger_cfg.rise_timeout + 1;
    if (rise_cap > 12) rise_cap = 12;
    fall_cap = ranger_cfg.fall_timeout + 2;
    if (fall_cap > 40) fall_cap = 40;
    lead  = $urandom_range(0, rise_cap);
    width = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, fall_cap);
    tail  = $urandom_range(1, 3);
    send_tick(1'b0, 1'b1, 1'b0, '0);
    repeat (lead) body_tick(1'b0, glitch_odds);
    repeat (width) body_tick(1'b1, glitch_odds);
    repeat (tail) body_tick(1'b0, glitch_odds);
  endtask

  // Accepted ticks feed the model; accepted reports are checked in order
  always @(posedge clk_i) begin
    echo_report_t calc, want, got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        calc = range_tick(s_axis_tdata[0], s_axis_tdata[1]);
        pending_reports.push_back(row_typed ? row_want : calc);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.trig    = m_axis_tdata[uer_pkg::OUT_TRIG_BIT];
        got.busy    = m_axis_tdata[uer_pkg::OUT_BUSY_BIT];
        got.done    = m_axis_tdata[uer_pkg::OUT_DONE_BIT];
        got.dist_cm = m_axis_tdata[uer_pkg::OUT_DIST_LSB +: uer_pkg::DistW];
        got.stat    = m_axis_tdata[uer_pkg::OUT_STAT_BIT];
        if (pending_reports.size() == 0) begin
          errors++;
          $display("%0t: item %h with no tick outstanding", $time, m_axis_tdata);
        end else begin
          want = pending_reports.pop_front();
          check_field("trigger_pulse", want.trig, got.trig);
          check_field("busy_res", want.busy, got.busy);
          check_field("done_res", want.done, got.done);
          check_field("distance_cm", want.dist_cm, got.dist_cm);
          check_field("status", want.stat, got.stat);
        end
        if (got.done) reports_seen++;
        if (got.done && got.stat) no_echo_seen++;
      end
    end
  end

  // Receiver: random stalls, with two long hold-offs to back the block up
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (items_drained == 300 || items_drained == 900) stall = HoldCycles;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      items_drained++;
      @(negedge clk_i);
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run stuck, %0d items still due", $time, pending_reports.size());
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int unsigned stop_at, phase_end;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = uer_pkg::CFG_RISE_TIMEOUT;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    row_typed     = 1'b0;
    row_want      = '0;
    no_idle       = 1'b0;
    errors        = 0;
    ticks_sent    = 0;
    reports_seen  = 0;
    no_echo_seen  = 0;
    reg_writes    = 0;
    items_drained = 0;

    ranger_cfg.rise_timeout = uer_pkg::RISE_TIMEOUT_RST;
    ranger_cfg.fall_timeout = uer_pkg::FALL_TIMEOUT_RST;
    ranger_cfg.pulse_limit  = uer_pkg::PULSE_LIMIT_RST;
    ranger_cfg.max_distance = uer_pkg::MAX_DISTANCE_RST;
    seq_phase = uer_pkg::PHASE_IDLE;
    echo_prev = 1'b0;
    measuring = 1'b0;
    pulse_cnt = '0;
    wait_cnt  = '0;

    dir_tab = '{
      // reset settings: idle, trigger, start ignored while busy, 3-tick echo
      tick_known(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 0, 1'b0),
      tick_known(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 0, 1'b0),
      tick_known(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 0, 1'b0),
      tick_open(1'b1, 1'b0),
      tick_open(1'b1, 1'b0),
      tick_known(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 5, 1'b0),
      // short waits: rise timeout gives no-echo, echo held through start is ignored
      reg_row(uer_pkg::CFG_RISE_TIMEOUT, 2),
      reg_row(uer_pkg::CFG_FALL_TIMEOUT, 3),
      tick_known(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 0, 1'b0),
      tick_open(1'b0, 1'b0),
      tick_known(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 400, 1'b1),
      tick_known(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 0, 1'b0),
      tick_open(1'b1, 1'b0),
      tick_known(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 400, 1'b1),
      // fall timeout while echo still high
      tick_known(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 0, 1'b0),
      tick_open(1'b1, 1'b0),
      tick_open(1'b1, 1'b0),
      tick_open(1'b1, 1'b0),
      tick_known(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 6, 1'b0),
      // pulse past the limit aborts the count
      reg_row(uer_pkg::CFG_PULSE_LIMIT, 2),
      reg_row(uer_pkg::CFG_RISE_TIMEOUT, 5),
      reg_row(uer_pkg::CFG_FALL_TIMEOUT, 10),
      reg_row(uer_pkg::CFG_MAX_DISTANCE, 1023),
      tick_known(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 0, 1'b0),
      tick_open(1'b1, 1'b0),
      tick_open(1'b1, 1'b0),
      tick_known(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1023, 1'b1),
      // all-zero registers: both waits end on the start tick, no-echo report of 0
      reg_row(uer_pkg::CFG_RISE_TIMEOUT, 0),
      reg_row(uer_pkg::CFG_FALL_TIMEOUT, 0),
      reg_row(uer_pkg::CFG_PULSE_LIMIT, 0),
      reg_row(uer_pkg::CFG_MAX_DISTANCE, 0),
      tick_known(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 0, 1'b1),
      tick_known(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 0, 1'b1)
    };

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows
    for (int i = 0; i < DirRows; i++) begin
      if (dir_tab[i].kind == ROW_WRITE)
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      else
        send_tick(dir_tab[i].echo, dir_tab[i].start, dir_tab[i].typed, dir_tab[i].want);
    end

    // random phases, fresh settings each time
    stop_at = ticks_sent + RandomTicks;
    while (ticks_sent < stop_at) begin
      write_reg(uer_pkg::CFG_RISE_TIMEOUT, pick_setting((1 << uer_pkg::RiseW) - 1, 24));
      write_reg(uer_pkg::CFG_FALL_TIMEOUT, pick_setting((1 << uer_pkg::WaitW) - 1, 40));
      write_reg(uer_pkg::CFG_PULSE_LIMIT, pick_setting((1 << uer_pkg::CountW) - 1, 60));
      write_reg(uer_pkg::CFG_MAX_DISTANCE, pick_setting((1 << uer_pkg::DistW) - 1, 120));
      no_idle   = ($urandom_range(0, 3) == 0);
      phase_end = ticks_sent + PhaseTicks;
      while (ticks_sent < phase_end) begin
        case ($urandom_range(0, 5))
          0: repeat ($urandom_range(5, 20))
               send_tick($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1, 1'b0, '0);
          1: echo_episode(6);
          default: echo_episode(0);
        endcase
      end
    end

    // full-scale registers: one long echo measured to the end
    no_idle = 1'b1;
    write_reg(uer_pkg::CFG_RISE_TIMEOUT, full_scale(uer_pkg::RiseW));
    write_reg(uer_pkg::CFG_FALL_TIMEOUT, full_scale(uer_pkg::WaitW));
    write_reg(uer_pkg::CFG_PULSE_LIMIT, full_scale(uer_pkg::CountW));
    write_reg(uer_pkg::CFG_MAX_DISTANCE, full_scale(uer_pkg::DistW));
    send_tick(1'b0, 1'b1, 1'b0, '0);
    repeat (LongRun) send_tick(1'b1, 1'b0, 1'b0, '0);
    send_tick(1'b0, 1'b1, 1'b0, '0);

    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("summary: %0d ticks, %0d register writes, %0d distance reports (%0d no-echo)",
             ticks_sent, reg_writes, reports_seen, no_echo_seen);
    $display("summary: echo episodes, noise and glitches, two %0d-cycle output stalls",
             HoldCycles);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/uer_pkg.sv
rtl/uer_seq.sv
rtl/ultrasonic_echo_ranger_top.sv
rtl/uer_checker.sv
verif/tb_top.sv
